/* rtl/core/mbox_pkg.sv */
package mbox_pkg;

    localparam int NUM_MAILBOXES_DEF = 8;
    localparam int FIFO_DEPTH_DEF = 4;
    localparam int USER_COUNT_DEF = 4;
    localparam logic [31:0] REVISION_VALUE_DEF = 32'd1024;

    localparam int ADDR_W = 9;
    localparam int DATA_W = 32;
    localparam int MAX_USERS = 4;

    localparam logic [ADDR_W-1:0] MSG_BASE = 9'h040;
    localparam logic [ADDR_W-1:0] FULL_BASE = 9'h080;
    localparam logic [ADDR_W-1:0] CNT_BASE = 9'h0c0;
    localparam logic [ADDR_W-1:0] USER_BASE = 9'h100;

    localparam logic [1:0] CFG_LAYOUT_MODE = 2'd0;

    typedef enum logic [3:0] {
        OP_NONE   = 4'd0,
        OP_REV    = 4'd1,
        OP_PUSH   = 4'd2,
        OP_POP    = 4'd3,
        OP_FULL   = 4'd4,
        OP_COUNT  = 4'd5,
        OP_STAT   = 4'd6,
        OP_ENSET  = 4'd7,
        OP_ENCLR  = 4'd8,
        OP_BAD    = 4'd9
    } op_t;

    typedef struct packed {
        logic       load;
        op_t        op;
        logic       wr;
        logic [3:0] mbox;
        logic [1:0] usr;
        logic       layout;
    } cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
    } sts_t;

endpackage

/* rtl/core/mbox_if.sv */
interface mbox_in_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [8:0]  address;
    logic [31:0] write_data;
    modport source (output valid, mode, address, write_data, input ready);
    modport sink (input valid, mode, address, write_data, output ready);
endinterface

interface mbox_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] read_data;
    logic [3:0]  irq_lines;
    logic        bad_address;
    modport source (output valid, read_data, irq_lines, bad_address, input ready);
    modport sink (input valid, read_data, irq_lines, bad_address, output ready);
endinterface

/* rtl/core/mbox_ctrl.sv */
module mbox_ctrl #(
    parameter int NUM_MAILBOXES = mbox_pkg::NUM_MAILBOXES_DEF,
    parameter int USER_COUNT = mbox_pkg::USER_COUNT_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 in_mode,
    input  logic [8:0]           in_address,
    input  logic                 layout,
    output logic                 out_valid,
    input  logic                 out_ready,
    output mbox_pkg::cmd_t       cmd
);
    import mbox_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_OUT  = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic   take;
    logic [8:0] a;
    logic [8:0] off;
    logic [3:0] m;
    logic [4:0] usr_w;
    logic [1:0] rg;

    assign a = in_address;
    // output register frees on take, so a new transfer may enter as the old leaves
    assign in_ready = (state_reg == ST_IDLE) || out_ready;
    assign take = in_valid && in_ready;
    assign out_valid = (state_reg == ST_OUT);
    assign off = a - USER_BASE;
    assign m = a[5:2];

    always_comb
    begin
        if (layout)
        begin
            usr_w = {1'b0, off[7:4]};
            rg = off[3:2];
        end
        else
        begin
            usr_w = off[7:3];
            rg = (off[2:0] == 3'd0) ? 2'd1 : 2'd2;
        end
    end

    always_comb
    begin
        cmd.load = take;
        cmd.wr = in_mode;
        cmd.mbox = m;
        cmd.usr = usr_w[1:0];
        cmd.layout = layout;
        cmd.op = OP_BAD;
        if (a[1:0] != 2'd0)
            cmd.op = OP_BAD;
        else if (a == 9'd0)
            cmd.op = OP_REV;
        else if (a < MSG_BASE)
            cmd.op = OP_BAD;
        else if (a < USER_BASE)
        begin
            if (32'(m) >= NUM_MAILBOXES)
                cmd.op = OP_BAD;
            else if (a < FULL_BASE)
                cmd.op = in_mode ? OP_PUSH : OP_POP;
            else if (a < CNT_BASE)
                cmd.op = OP_FULL;
            else
                cmd.op = OP_COUNT;
        end
        else if (32'(usr_w) >= USER_COUNT || rg == 2'd0)
            cmd.op = OP_BAD;
        else if (rg == 2'd1)
            cmd.op = OP_STAT;
        else if (rg == 2'd2)
            cmd.op = OP_ENSET;
        else
            cmd.op = OP_ENCLR;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (take) state_next = ST_OUT;
            ST_OUT:  if (out_ready && !take) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_reg))
        else $error("state not one-hot");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid) else $error("result lost");
    a_take: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> out_valid) else $error("no result after transfer");
endmodule

/* rtl/core/mbox_dp.sv */
module mbox_dp #(
    parameter int NUM_MAILBOXES = mbox_pkg::NUM_MAILBOXES_DEF,
    parameter int FIFO_DEPTH = mbox_pkg::FIFO_DEPTH_DEF,
    parameter int USER_COUNT = mbox_pkg::USER_COUNT_DEF,
    parameter logic [31:0] REVISION_VALUE = mbox_pkg::REVISION_VALUE_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  mbox_pkg::cmd_t cmd,
    input  logic [31:0]    write_data,
    output logic [31:0]    read_data,
    output logic [3:0]     irq_lines,
    output logic           bad_address
);
    import mbox_pkg::*;

    localparam int PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CW = $clog2(FIFO_DEPTH + 1);
    localparam int MW = (NUM_MAILBOXES > 1) ? $clog2(NUM_MAILBOXES) : 1;
    localparam int SW = 2 * NUM_MAILBOXES;
    localparam int UW = (USER_COUNT > 1) ? $clog2(USER_COUNT) : 1;
    localparam int AW = (NUM_MAILBOXES * FIFO_DEPTH > 1) ?
        $clog2(NUM_MAILBOXES * FIFO_DEPTH) : 1;

    logic [31:0]   mem [NUM_MAILBOXES * FIFO_DEPTH];
    logic [CW-1:0] cnt_reg [NUM_MAILBOXES];
    logic [PW-1:0] rp_reg [NUM_MAILBOXES];
    logic [SW-1:0] stat_reg [USER_COUNT];
    logic [SW-1:0] en_reg [USER_COUNT];
    logic [31:0]   rd_reg;
    logic [31:0]   rd_next;
    logic          bad_reg;
    logic          popsel_reg;
    logic [MW-1:0] mi;
    logic [UW-1:0] ui;
    logic [CW-1:0] c;
    logic [PW-1:0] rp;
    logic [PW:0]   wsum;
    logic [PW-1:0] wp;
    logic [PW-1:0] rp_inc;
    logic [AW-1:0] waddr;
    logic [AW-1:0] raddr;
    logic          full;
    logic          empty;
    logic          do_push;
    logic          do_pop;
    logic [SW-1:0] setbits;
    logic [SW-1:0] dmask;
    logic [31:0]   mem_q;
    logic [3:0]    lines;

    assign mi = cmd.mbox[MW-1:0];
    assign ui = cmd.usr[UW-1:0];
    assign c = cnt_reg[mi];
    assign rp = rp_reg[mi];
    assign full = (32'(c) >= FIFO_DEPTH);
    assign empty = (c == '0);
    assign do_push = cmd.load && cmd.op == OP_PUSH && !full;
    assign do_pop = cmd.load && cmd.op == OP_POP && !empty;
    assign wsum = {1'b0, rp} + (PW+1)'(c);
    assign wp = (32'(wsum) >= FIFO_DEPTH) ? PW'(32'(wsum) - FIFO_DEPTH) : wsum[PW-1:0];
    assign rp_inc = (32'(rp) + 1 >= FIFO_DEPTH) ? '0 : PW'(rp + 1'b1);
    assign waddr = AW'(32'(mi) * FIFO_DEPTH + 32'(wp));
    assign raddr = AW'(32'(mi) * FIFO_DEPTH + 32'(rp));
    assign dmask = write_data[SW-1:0];

    always_comb
    begin
        setbits = '0;
        if (do_push)
            setbits[2*mi] = 1'b1;
        if (do_pop && full)
            setbits[2*mi+1] = 1'b1;
    end

    always_comb
    begin
        rd_next = '0;
        if (!cmd.wr)
        begin
            case (cmd.op)
                OP_REV:   rd_next = REVISION_VALUE;
                OP_FULL:  rd_next = {31'd0, full};
                OP_COUNT: rd_next = 32'(c);
                OP_STAT:  rd_next = 32'(stat_reg[ui]);
                OP_ENSET: rd_next = 32'(en_reg[ui]);
                OP_ENCLR: rd_next = 32'(en_reg[ui]);
                default:  rd_next = '0;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[waddr] <= write_data;
        if (do_pop)
            mem_q <= mem[raddr];
        if (cmd.load)
            rd_reg <= rd_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_MAILBOXES; i++)
            begin
                cnt_reg[i] <= '0;
                rp_reg[i] <= '0;
            end
            for (int u = 0; u < USER_COUNT; u++)
            begin
                stat_reg[u] <= '0;
                en_reg[u] <= '0;
            end
            bad_reg <= 1'b0;
            popsel_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            bad_reg <= (cmd.op == OP_BAD);
            popsel_reg <= do_pop;
            if (do_push)
                cnt_reg[mi] <= c + 1'b1;
            if (do_pop)
            begin
                cnt_reg[mi] <= c - 1'b1;
                rp_reg[mi] <= rp_inc;
            end
            for (int u = 0; u < USER_COUNT; u++)
            begin
                logic [SW-1:0] s;
                logic [SW-1:0] e;
                s = stat_reg[u] | setbits;
                e = en_reg[u];
                if (UW'(u) == ui && cmd.wr)
                begin
                    if (cmd.op == OP_STAT)
                        s = s & ~dmask;
                    if (cmd.op == OP_ENSET)
                        e = cmd.layout ? (e | dmask) : dmask;
                    if (cmd.op == OP_ENCLR)
                        e = e & ~dmask;
                end
                stat_reg[u] <= s;
                en_reg[u] <= e;
            end
        end
    end

    always_comb
    begin
        lines = '0;
        for (int u = 0; u < USER_COUNT; u++)
            lines[u] = |(stat_reg[u] & en_reg[u]);
    end

    assign irq_lines = lines;
    assign bad_address = bad_reg;
    assign read_data = popsel_reg ? mem_q : rd_reg;

    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        bad_reg && !popsel_reg |-> rd_reg == '0) else $error("bad access returned data");
    a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        32'(c) <= FIFO_DEPTH) else $error("count overflow");
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(do_push && do_pop)) else $error("push and pop together");
endmodule

/* rtl/core/mailbox_fifo_interrupt_registers.sv */
// The result is registered and becomes valid in the cycle after the input transfer.
// Throughput: one access per cycle while out_ready stays high; the result register is refilled as it is taken.
// FIFO words sit in a single-port memory; counts, pointers, status and enable are flops.
// Reset (rst_n, asynchronous, active low) empties all FIFOs, clears status and enable,
// and clears the layout select (layout_reg) to 0. FIFO contents are undefined until written.
module mailbox_fifo_interrupt_registers #(
    parameter int NUM_MAILBOXES = mbox_pkg::NUM_MAILBOXES_DEF,
    parameter int FIFO_DEPTH = mbox_pkg::FIFO_DEPTH_DEF,
    parameter int USER_COUNT = mbox_pkg::USER_COUNT_DEF,
    parameter logic [31:0] REVISION_VALUE = mbox_pkg::REVISION_VALUE_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    mbox_in_if.sink     in_ch,
    mbox_out_if.source  out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [0:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import mbox_pkg::*;

    cmd_t cmd;
    logic layout_reg;

    assign pready = 1'b1;
    assign prdata = {31'd0, layout_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            layout_reg <= 1'b0;
        else if (psel && penable && pwrite && paddr == 1'b0)
            layout_reg <= pwdata[0];
    end

    mbox_ctrl #(.NUM_MAILBOXES(NUM_MAILBOXES), .USER_COUNT(USER_COUNT)) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_ch.valid),
        .in_ready   (in_ch.ready),
        .in_mode    (in_ch.mode),
        .in_address (in_ch.address),
        .layout     (layout_reg),
        .out_valid  (out_ch.valid),
        .out_ready  (out_ch.ready),
        .cmd        (cmd)
    );

    mbox_dp #(
        .NUM_MAILBOXES  (NUM_MAILBOXES),
        .FIFO_DEPTH     (FIFO_DEPTH),
        .USER_COUNT     (USER_COUNT),
        .REVISION_VALUE (REVISION_VALUE)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .write_data  (in_ch.write_data),
        .read_data   (out_ch.read_data),
        .irq_lines   (out_ch.irq_lines),
        .bad_address (out_ch.bad_address)
    );
endmodule
